// File: sv/voxel_importance_split_roulette_assert.svh
// Assertion helpers shared by the checker.
`ifndef VOXEL_IMPORTANCE_SPLIT_ROULETTE_ASSERT_SVH
`define VOXEL_IMPORTANCE_SPLIT_ROULETTE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/vis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vis_pkg;

  typedef enum logic [2:0] {
    ACT_UNCHANGED = 3'd0,
    ACT_SPLIT     = 3'd1,
    ACT_SURVIVED  = 3'd2,
    ACT_KILLED    = 3'd3,
    ACT_LOADED    = 3'd4,
    ACT_ERROR     = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    REG_COUNT_X = 2'd0,
    REG_COUNT_Y = 2'd1,
    REG_COUNT_Z = 2'd2
  } reg_idx_t;

  // flat voxel index width: 6b*7b*7b + 6b*7b + 6b
  localparam int unsigned IDX_W      = 21;
  // divider: 32 quotient bits, 4 per stage
  localparam int unsigned DIV_STAGES = 8;
  localparam int unsigned DIV_BITS   = 4;

  typedef struct packed {
    logic        req_type;
    logic        handled;
    logic        pre_ok;
    logic        post_ok;
    logic [31:0] weight;
    logic [15:0] rnd;
    logic [31:0] impval;
  } idx_word_t;

  typedef struct packed {
    action_t     act;
    logic        fin;
    logic [31:0] weight;
    logic [15:0] rnd;
    logic [31:0] pre;
    logic [31:0] post;
  } tbl_word_t;

  typedef struct packed {
    action_t     act;
    logic        fin;
    logic [31:0] weight;
    logic [5:0]  extra;
    logic        sat;
    logic        zpost;
    logic        nz;
  } div_tag_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] quo;
    logic [31:0] dvs;
  } div_word_t;

  // DIV_BITS restoring steps of a long division, remainder kept below divisor
  function automatic div_word_t div_step(div_word_t w);
    div_word_t   v;
    logic [32:0] r;
    v = w;
    for (int i = 0; i < DIV_BITS; i++) begin
      r    = {v.rem, v.lo[31]};
      v.lo = {v.lo[30:0], 1'b0};
      if (r >= {1'b0, v.dvs}) begin
        r     = r - {1'b0, v.dvs};
        v.quo = {v.quo[30:0], 1'b1};
      end else begin
        v.quo = {v.quo[30:0], 1'b0};
      end
      v.rem = r[31:0];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/vis_if.sv
`timescale 1ns / 1ps
`default_nettype none

// step / load word channel
interface vis_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        at_boundary;
  logic        is_first_step;
  logic [5:0]  pre_x;
  logic [5:0]  pre_y;
  logic [5:0]  pre_z;
  logic [5:0]  post_x;
  logic [5:0]  post_y;
  logic [5:0]  post_z;
  logic [31:0] track_weight;
  logic [15:0] rand_fraction;
  logic [31:0] importance_value;

  modport source (
    output valid, req_type, at_boundary, is_first_step, pre_x, pre_y, pre_z,
           post_x, post_y, post_z, track_weight, rand_fraction, importance_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, at_boundary, is_first_step, pre_x, pre_y, pre_z,
           post_x, post_y, post_z, track_weight, rand_fraction, importance_value,
    output ready
  );
  modport monitor (
    input valid, ready, req_type, at_boundary, is_first_step, pre_x, pre_y, pre_z,
          post_x, post_y, post_z, track_weight, rand_fraction, importance_value
  );
endinterface

// result word channel
interface vis_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [5:0]  extra_copies;
  logic [31:0] new_weight;

  modport source (output valid, action, extra_copies, new_weight, input ready);
  modport sink   (input valid, action, extra_copies, new_weight, output ready);
  modport monitor (input valid, ready, action, extra_copies, new_weight);
endinterface

`default_nettype wire

// File: sv/vis_index.sv
`timescale 1ns / 1ps
`default_nettype none

// Input register and two stages of voxel index arithmetic.
module vis_index #(
  parameter int unsigned MAX_VOXELS = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_en,
  input  logic [6:0]          count_y,
  input  logic [6:0]          count_z,
  vis_in_if.sink              in_ch,
  output logic                c_vld,
  output vis_pkg::idx_word_t  c_word,
  output logic [((MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1)-1:0] pre_addr,
  output logic [((MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1)-1:0] post_addr
);

  localparam int unsigned AW = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
  localparam int unsigned IW = vis_pkg::IDX_W;
  localparam logic [IW-1:0] VOX_LIM = IW'(MAX_VOXELS);

  logic               in_fire;
  logic               a_vld_r, b_vld_r, c_vld_r;
  vis_pkg::idx_word_t a_word_r, b_word_r, c_word_r;
  logic [5:0]         a_px_r, a_py_r, a_pz_r, a_qx_r, a_qy_r, a_qz_r;
  logic [12:0]        b_pxy_r, b_qxy_r;
  logic [13:0]        b_pyz_r, b_qyz_r;
  logic [IW-1:0]      pre_idx, post_idx;
  logic [AW-1:0]      pre_addr_r, post_addr_r;

  assign in_ch.ready = in_en;
  assign in_fire     = in_ch.valid && in_en;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_fire;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  // flat index: x*cy*cz + y*cz + z
  always_comb begin
    pre_idx  = {8'd0, b_pxy_r} * {14'd0, count_z} + {7'd0, b_pyz_r};
    post_idx = {8'd0, b_qxy_r} * {14'd0, count_z} + {7'd0, b_qyz_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // input register
      a_word_r.req_type <= in_ch.req_type;
      a_word_r.handled  <= in_ch.at_boundary && !in_ch.is_first_step;
      a_word_r.pre_ok   <= 1'b0;
      a_word_r.post_ok  <= 1'b0;
      a_word_r.weight   <= in_ch.track_weight;
      a_word_r.rnd      <= in_ch.rand_fraction;
      a_word_r.impval   <= in_ch.importance_value;
      a_px_r <= in_ch.pre_x;
      a_py_r <= in_ch.pre_y;
      a_pz_r <= in_ch.pre_z;
      a_qx_r <= in_ch.post_x;
      a_qy_r <= in_ch.post_y;
      a_qz_r <= in_ch.post_z;
      // partial products
      b_word_r <= a_word_r;
      b_pxy_r  <= {7'd0, a_px_r} * {6'd0, count_y};
      b_qxy_r  <= {7'd0, a_qx_r} * {6'd0, count_y};
      b_pyz_r  <= {8'd0, a_py_r} * {7'd0, count_z} + {8'd0, a_pz_r};
      b_qyz_r  <= {8'd0, a_qy_r} * {7'd0, count_z} + {8'd0, a_qz_r};
      // range check and address
      c_word_r    <= {b_word_r.req_type, b_word_r.handled, pre_idx < VOX_LIM,
                      post_idx < VOX_LIM, b_word_r.weight, b_word_r.rnd, b_word_r.impval};
      pre_addr_r  <= pre_idx[AW-1:0];
      post_addr_r <= post_idx[AW-1:0];
    end
  end

  assign c_vld     = c_vld_r;
  assign c_word    = c_word_r;
  assign pre_addr  = pre_addr_r;
  assign post_addr = post_addr_r;

endmodule

`default_nettype wire

// File: sv/vis_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Importance memory: clearing pass after reset, load writes, two registered reads.
module vis_table #(
  parameter int unsigned MAX_VOXELS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               c_vld,
  input  vis_pkg::idx_word_t c_word,
  input  logic [((MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1)-1:0] pre_addr,
  input  logic [((MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1)-1:0] post_addr,
  output logic               clearing,
  output logic               d_vld,
  output vis_pkg::tbl_word_t d_word
);

  localparam int unsigned AW = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
  localparam logic [AW-1:0] LAST = AW'(MAX_VOXELS - 1);

  logic [31:0]      mem [MAX_VOXELS];
  logic [31:0]      pre_q_r, post_q_r;
  logic             clr_r;
  logic [AW-1:0]    clr_cnt_r;
  logic             d_vld_r, d_fin_r;
  vis_pkg::action_t d_act_r, act_nxt;
  logic             fin_nxt;
  logic [31:0]      d_weight_r;
  logic [15:0]      d_rnd_r;

  // clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST) begin
        clr_r <= 1'b0;
      end
    end
  end

  // memory port
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (adv && c_vld && !c_word.req_type && c_word.pre_ok) begin
      mem[pre_addr] <= c_word.impval;
    end
    if (adv) begin
      pre_q_r  <= mem[pre_addr];
      post_q_r <= mem[post_addr];
    end
  end

  // early outcomes that need no table data
  always_comb begin
    act_nxt = vis_pkg::ACT_UNCHANGED;
    fin_nxt = 1'b1;
    if (!c_word.req_type) begin
      act_nxt = c_word.pre_ok ? vis_pkg::ACT_LOADED : vis_pkg::ACT_ERROR;
    end else if (!c_word.handled) begin
      act_nxt = vis_pkg::ACT_UNCHANGED;
    end else if (!(c_word.pre_ok && c_word.post_ok)) begin
      act_nxt = vis_pkg::ACT_ERROR;
    end else begin
      fin_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_act_r    <= act_nxt;
      d_fin_r    <= fin_nxt;
      d_weight_r <= c_word.weight;
      d_rnd_r    <= c_word.rnd;
    end
  end

  always_comb begin
    d_word.act    = d_act_r;
    d_word.fin    = d_fin_r;
    d_word.weight = d_weight_r;
    d_word.rnd    = d_rnd_r;
    d_word.pre    = pre_q_r;
    d_word.post   = post_q_r;
  end

  assign clearing = clr_r;
  assign d_vld    = d_vld_r;

endmodule

`default_nettype wire

// File: sv/vis_ratio.sv
`timescale 1ns / 1ps
`default_nettype none

// Split / roulette decision, split count post/pre, divider setup.
module vis_ratio #(
  parameter int unsigned MAX_SPLIT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                d_vld,
  input  vis_pkg::tbl_word_t  d_word,
  output logic                f_vld,
  output vis_pkg::div_word_t  f_dvd,
  output vis_pkg::div_tag_t   f_tag
);

  localparam logic [6:0] SPLIT_CAP = 7'(MAX_SPLIT);

  vis_pkg::action_t   act, e_act_r;
  logic               fin, kill, cap, e_fin_r, e_cap_r, e_vld_r, f_vld_r;
  logic [31:0]        r, e_rem_r, e_weight_r, e_pre_r, e_post_r, rf;
  logic [37:0]        sh, shf;
  logic [2:0]         qh, e_q_r, ql;
  logic [63:0]        num, e_num_r;
  logic [47:0]        kprod;
  logic [6:0]         qn, n;
  vis_pkg::div_word_t dvd;
  vis_pkg::div_tag_t  tag;
  vis_pkg::div_word_t f_dvd_r;
  vis_pkg::div_tag_t  f_tag_r;

  // stage E: products, cap test, upper quotient bits, outcome
  always_comb begin
    num   = {32'd0, d_word.weight} * {32'd0, d_word.pre};
    kprod = {32'd0, d_word.rnd} * {16'd0, d_word.pre};
    kill  = kprod > {d_word.post, 16'd0};
    cap   = {6'd0, d_word.post} >= {d_word.pre, 6'd0};
    r     = d_word.post;
    qh    = '0;
    sh    = '0;
    for (int i = 0; i < 3; i++) begin
      sh = {6'd0, d_word.pre} << (5 - i);
      if ({6'd0, r} >= sh) begin
        r         = r - sh[31:0];
        qh[2 - i] = 1'b1;
      end
    end
    act = d_word.act;
    fin = d_word.fin;
    if (!d_word.fin) begin
      if (d_word.pre == 32'd0) begin
        act = vis_pkg::ACT_ERROR;
        fin = 1'b1;
      end else if (d_word.post > d_word.pre) begin
        act = vis_pkg::ACT_SPLIT;
      end else if (kill) begin
        act = vis_pkg::ACT_KILLED;
        fin = 1'b1;
      end else begin
        act = vis_pkg::ACT_SURVIVED;
      end
    end
  end

  // stage F: lower quotient bits, cap, divider operands
  always_comb begin
    rf  = e_rem_r;
    ql  = '0;
    shf = '0;
    for (int i = 0; i < 3; i++) begin
      shf = {6'd0, e_pre_r} << (2 - i);
      if ({6'd0, rf} >= shf) begin
        rf        = rf - shf[31:0];
        ql[2 - i] = 1'b1;
      end
    end
    qn = e_cap_r ? 7'd64 : {1'b0, e_q_r, ql};
    n  = (qn > SPLIT_CAP) ? SPLIT_CAP : qn;

    dvd.quo = '0;
    if (e_act_r == vis_pkg::ACT_SPLIT) begin
      dvd.rem = '0;
      dvd.lo  = e_weight_r;
      dvd.dvs = {25'd0, n};
    end else begin
      dvd.rem = e_num_r[63:32];
      dvd.lo  = e_num_r[31:0];
      dvd.dvs = e_post_r;
    end

    tag.act    = e_act_r;
    tag.fin    = e_fin_r;
    tag.weight = e_weight_r;
    tag.extra  = 6'(n - 7'd1);
    tag.sat    = e_num_r[63:32] >= e_post_r;
    tag.zpost  = e_post_r == 32'd0;
    tag.nz     = e_num_r == 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= d_vld;
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_act_r    <= act;
      e_fin_r    <= fin;
      e_cap_r    <= cap;
      e_rem_r    <= r;
      e_q_r      <= qh;
      e_num_r    <= num;
      e_weight_r <= d_word.weight;
      e_pre_r    <= d_word.pre;
      e_post_r   <= d_word.post;
      f_dvd_r    <= dvd;
      f_tag_r    <= tag;
    end
  end

  assign f_vld = f_vld_r;
  assign f_dvd = f_dvd_r;
  assign f_tag = f_tag_r;

endmodule

`default_nettype wire

// File: sv/vis_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined 64/32 restoring divider, 4 quotient bits per stage.
module vis_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  vis_pkg::div_word_t in_word,
  input  vis_pkg::div_tag_t  in_tag,
  output logic               out_vld,
  output vis_pkg::div_word_t out_word,
  output vis_pkg::div_tag_t  out_tag
);

  localparam int unsigned NS = vis_pkg::DIV_STAGES;

  logic [NS-1:0]      vld_r;
  vis_pkg::div_word_t word_r [NS];
  vis_pkg::div_tag_t  tag_r  [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  // one group of quotient bits per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      word_r[0] <= vis_pkg::div_step(in_word);
      tag_r[0]  <= in_tag;
      for (int s = 1; s < NS; s++) begin
        word_r[s] <= vis_pkg::div_step(word_r[s-1]);
        tag_r[s]  <= tag_r[s-1];
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_word = word_r[NS-1];
  assign out_tag  = tag_r[NS-1];

endmodule

`default_nettype wire

// File: sv/voxel_importance_split_roulette.sv
// Voxel importance splitting and roulette.
// in_ch carries load and track-step words (valid/ready); out_ch returns one
// result word per accepted input word, in order (action, extra_copies,
// new_weight). The count_x/y/z registers sit on the cfg_ APB port at byte
// addresses 0, 4 and 8; write them only while the pipeline is empty.
// Throughput: one word per cycle unless stalled. Path from acceptance to
// out_ch.valid: input register, two index stages, the table read, two ratio
// stages, eight divider stages (4 quotient bits each) and the output register.
// An in-range load writes the table as it passes the read stage, so any
// later step sees the new value.
// Reset: registers return to 1 and the importance table is swept to zero,
// one entry per cycle over all MAX_VOXELS entries, with in_ch.ready low;
// config writes are taken during the sweep.
// Stall: the whole pipeline holds while out_ch.valid is high and out_ch.ready
// is low; in_ch.ready drops in the same cycle, nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module voxel_importance_split_roulette #(
  parameter int unsigned MAX_VOXELS = 65536,
  parameter int unsigned MAX_SPLIT  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  vis_in_if.sink      in_ch,
  vis_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned AW = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;

  logic               adv, clearing;
  logic [6:0]         count_x_r, count_y_r, count_z_r;
  logic               c_vld, d_vld, f_vld, g_vld;
  vis_pkg::idx_word_t c_word;
  vis_pkg::tbl_word_t d_word;
  vis_pkg::div_word_t f_dvd, g_word;
  vis_pkg::div_tag_t  f_tag, g_tag;
  logic [AW-1:0]      pre_addr, post_addr;
  logic               out_vld_r;
  logic [2:0]         out_act_r;
  logic [5:0]         out_extra_r;
  logic [31:0]        out_w_r, w_nxt;
  logic [5:0]         extra_nxt;

  // whole pipeline moves unless the output word is stuck
  assign adv = !out_vld_r || out_ch.ready;

  // configuration registers
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_x_r <= 7'd1;
      count_y_r <= 7'd1;
      count_z_r <= 7'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (vis_pkg::reg_idx_t'(cfg_paddr[3:2]))
        vis_pkg::REG_COUNT_X: count_x_r <= cfg_pwdata[6:0];
        vis_pkg::REG_COUNT_Y: count_y_r <= cfg_pwdata[6:0];
        vis_pkg::REG_COUNT_Z: count_z_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (vis_pkg::reg_idx_t'(cfg_paddr[3:2]))
      vis_pkg::REG_COUNT_X: cfg_prdata = {25'd0, count_x_r};
      vis_pkg::REG_COUNT_Y: cfg_prdata = {25'd0, count_y_r};
      vis_pkg::REG_COUNT_Z: cfg_prdata = {25'd0, count_z_r};
      default:              cfg_prdata = '0;
    endcase
  end

  vis_index #(.MAX_VOXELS(MAX_VOXELS)) u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_en     (adv && !clearing),
    .count_y   (count_y_r),
    .count_z   (count_z_r),
    .in_ch     (in_ch),
    .c_vld     (c_vld),
    .c_word    (c_word),
    .pre_addr  (pre_addr),
    .post_addr (post_addr)
  );

  vis_table #(.MAX_VOXELS(MAX_VOXELS)) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .c_vld     (c_vld),
    .c_word    (c_word),
    .pre_addr  (pre_addr),
    .post_addr (post_addr),
    .clearing  (clearing),
    .d_vld     (d_vld),
    .d_word    (d_word)
  );

  vis_ratio #(.MAX_SPLIT(MAX_SPLIT)) u_ratio (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .d_vld  (d_vld),
    .d_word (d_word),
    .f_vld  (f_vld),
    .f_dvd  (f_dvd),
    .f_tag  (f_tag)
  );

  vis_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (f_vld),
    .in_word  (f_dvd),
    .in_tag   (f_tag),
    .out_vld  (g_vld),
    .out_word (g_word),
    .out_tag  (g_tag)
  );

  // final weight selection
  always_comb begin
    extra_nxt = '0;
    if (g_tag.fin) begin
      w_nxt = (g_tag.act == vis_pkg::ACT_UNCHANGED) ? g_tag.weight : 32'd0;
    end else if (g_tag.act == vis_pkg::ACT_SPLIT) begin
      w_nxt     = g_word.quo;
      extra_nxt = g_tag.extra;
    end else if (g_tag.zpost) begin
      w_nxt = g_tag.nz ? 32'd0 : 32'hFFFF_FFFF;
    end else if (g_tag.sat) begin
      w_nxt = 32'hFFFF_FFFF;
    end else begin
      w_nxt = g_word.quo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_act_r   <= g_tag.act;
      out_extra_r <= extra_nxt;
      out_w_r     <= w_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.action       = out_act_r;
  assign out_ch.extra_copies = out_extra_r;
  assign out_ch.new_weight   = out_w_r;

endmodule

`default_nettype wire

// File: sv/vis_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_importance_split_roulette_assert.svh"

// Port-level checks on the block.
module vis_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_action,
  input logic [5:0]  out_extra,
  input logic [31:0] out_weight
);

  // table sweep keeps the input closed right after reset
  `VIS_ASSERT_NOW(a_sweep_closed, !$past(rst_n), !in_ready, "input open during sweep")

  `VIS_ASSERT_NOW(a_action_code, out_valid, out_action <= vis_pkg::ACT_ERROR, "bad action")

  // only a split reports copies
  `VIS_ASSERT_NOW(a_extra_split, out_valid && out_action != vis_pkg::ACT_SPLIT, out_extra == 6'd0, "copies without split")

  // killed, loaded and error words carry no weight
  `VIS_ASSERT_NOW(a_zero_weight, out_valid && (out_action == vis_pkg::ACT_KILLED || out_action == vis_pkg::ACT_LOADED || out_action == vis_pkg::ACT_ERROR), out_weight == 32'd0, "weight on dead word")

  `VIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_weight) && $stable(out_action), "stalled word changed")

endmodule

bind voxel_importance_split_roulette vis_props u_vis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_action (out_ch.action),
  .out_extra  (out_ch.extra_copies),
  .out_weight (out_ch.new_weight)
);

`default_nettype wire
